// ===== rtl/next_permutation_digits_top_defines.svh =====
// Assertion macros for the next permutation block.
`ifndef NEXT_PERMUTATION_DIGITS_TOP_DEFINES_SVH
`define NEXT_PERMUTATION_DIGITS_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define NPD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("npd: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define NPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("npd: next-cycle check failed");

`endif

// ===== rtl/npd_pkg.sv =====
`default_nettype none
package npd_pkg;

    // Store depth default
    localparam int MAX_DIGITS_DEF = 16;

    // Digit encoding
    localparam int         DIGIT_W     = 4;
    localparam logic [3:0] DIGIT_LIMIT = 4'd10;
    localparam logic [3:0] DIGIT_MAX   = 4'd9;

    // Sequencer states
    typedef enum logic [2:0] {
        S_LOAD,
        S_PREP,
        S_SCAN,
        S_SEARCH,
        S_PRE,
        S_SWAP,
        S_SUF,
        S_NONE
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/next_permutation_digits_top.sv =====
// Operation: one digit is loaded per accepted input beat, then a prepare step, a pivot scan,
// a search for the swap digit and n output beats follow; a sequence with no answer gives one beat.
// No new sequence is taken until the last one has been put out (o_stall is high outside loading).
// The scan, search and output walks share the single read port of the digit store.
// Reset: synchronous, active low; clears the sequencer, digit count and output valid.
// The digit store is not cleared: only entries written in the current sequence are read.
`default_nettype none
`include "next_permutation_digits_top_defines.svh"

module next_permutation_digits_top #(
    parameter int MAX_DIGITS = npd_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [npd_pkg::DIGIT_W-1:0] i_digit_in,
    input  wire logic                        i_last_in,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [npd_pkg::DIGIT_W-1:0]      o_digit_out,
    output logic                             o_found,
    output logic                             o_last_out
);

    localparam int DW = npd_pkg::DIGIT_W;
    localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int CW = $clog2(MAX_DIGITS + 1);

    // Digit store
    logic [DW-1:0] mem [MAX_DIGITS];

    npd_pkg::t_state r_state, n_state;

    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_n;
    logic [AW-1:0] r_addr, n_addr;
    logic [DW-1:0] r_rdata;
    logic [DW-1:0] r_prev, n_prev;
    logic [AW-1:0] r_pos, n_pos;
    logic [DW-1:0] r_p, n_p;
    logic [AW-1:0] r_bi, n_bi;
    logic [DW-1:0] r_s, n_s;

    logic          r_ovalid;
    logic [DW-1:0] r_odigit;
    logic          r_ofound;
    logic          r_olast;

    logic          accept;
    logic          cnt_room;
    logic [DW-1:0] d_clamped;
    logic [CW-1:0] n_minus;
    logic [AW-1:0] last_idx;
    logic [AW-1:0] pos_m1;
    logic [AW-1:0] pos_p1;
    logic          scan_hit;
    logic          search_hit;
    logic          out_free;

    logic          emit;
    logic [DW-1:0] e_digit;
    logic          e_found;
    logic          e_last;

    // Handshake and helpers
    assign o_stall    = (r_state != npd_pkg::S_LOAD);
    assign accept     = i_valid && !o_stall;
    assign cnt_room   = (r_cnt < CW'(MAX_DIGITS));
    assign d_clamped  = (i_digit_in >= npd_pkg::DIGIT_LIMIT) ? npd_pkg::DIGIT_MAX : i_digit_in;
    assign n_cnt      = cnt_room ? (r_cnt + CW'(1)) : r_cnt;
    assign n_minus    = r_n - CW'(1);
    assign last_idx   = n_minus[AW-1:0];
    assign pos_m1     = r_pos - AW'(1);
    assign pos_p1     = r_pos + AW'(1);
    // pivot: first digit from the right smaller than its right neighbour
    assign scan_hit   = (r_addr != last_idx) && (r_rdata < r_prev);
    // suffix is non-increasing, so the first larger digit from the right is the smallest
    assign search_hit = (r_rdata > r_p);
    assign out_free   = !r_ovalid || !i_stall;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            npd_pkg::S_LOAD: begin
                if (accept && i_last_in) n_state = npd_pkg::S_PREP;
            end
            npd_pkg::S_PREP: begin
                n_state = npd_pkg::S_SCAN;
            end
            npd_pkg::S_SCAN: begin
                if (scan_hit)            n_state = npd_pkg::S_SEARCH;
                else if (r_addr == '0)   n_state = npd_pkg::S_NONE;
            end
            npd_pkg::S_SEARCH: begin
                if (search_hit) n_state = (r_pos == '0) ? npd_pkg::S_SWAP : npd_pkg::S_PRE;
            end
            npd_pkg::S_PRE: begin
                if (out_free && (r_addr == pos_m1)) n_state = npd_pkg::S_SWAP;
            end
            npd_pkg::S_SWAP: begin
                if (out_free) n_state = npd_pkg::S_SUF;
            end
            npd_pkg::S_SUF: begin
                if (out_free && (r_addr == pos_p1)) n_state = npd_pkg::S_LOAD;
            end
            npd_pkg::S_NONE: begin
                if (out_free) n_state = npd_pkg::S_LOAD;
            end
            default: n_state = npd_pkg::S_LOAD;
        endcase
    end

    // Datapath and output beats
    always_comb begin
        n_addr  = r_addr;
        n_prev  = r_prev;
        n_pos   = r_pos;
        n_p     = r_p;
        n_bi    = r_bi;
        n_s     = r_s;
        emit    = 1'b0;
        e_digit = '0;
        e_found = 1'b1;
        e_last  = 1'b0;
        unique case (r_state)
            npd_pkg::S_LOAD: begin
                n_addr = r_addr;
            end
            npd_pkg::S_PREP: begin
                n_addr = last_idx;
            end
            npd_pkg::S_SCAN: begin
                if (scan_hit) begin
                    n_pos  = r_addr;
                    n_p    = r_rdata;
                    n_addr = last_idx;
                end else begin
                    n_prev = r_rdata;
                    n_addr = r_addr - AW'(1);
                end
            end
            npd_pkg::S_SEARCH: begin
                if (search_hit) begin
                    n_bi   = r_addr;
                    n_s    = r_rdata;
                    n_addr = '0;
                end else begin
                    n_addr = r_addr - AW'(1);
                end
            end
            npd_pkg::S_PRE: begin
                emit    = out_free;
                e_digit = r_rdata;
                if (out_free) n_addr = r_addr + AW'(1);
            end
            npd_pkg::S_SWAP: begin
                emit    = out_free;
                e_digit = r_s;
                if (out_free) n_addr = last_idx;
            end
            npd_pkg::S_SUF: begin
                // suffix read backwards comes out ascending; pivot digit takes the swapped slot
                emit    = out_free;
                e_digit = (r_addr == r_bi) ? r_p : r_rdata;
                e_last  = (r_addr == pos_p1);
                if (out_free && !e_last) n_addr = r_addr - AW'(1);
            end
            npd_pkg::S_NONE: begin
                emit    = out_free;
                e_found = 1'b0;
                e_last  = 1'b1;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // Store write and registered read
    always_ff @(posedge i_clk) begin
        if (accept && cnt_room) begin
            mem[r_cnt[AW-1:0]] <= d_clamped;
        end
        r_rdata <= mem[n_addr];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= npd_pkg::S_LOAD;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_cnt <= i_last_in ? '0 : n_cnt;
            end
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_prev <= n_prev;
        r_pos  <= n_pos;
        r_p    <= n_p;
        r_bi   <= n_bi;
        r_s    <= n_s;
        if (accept && i_last_in) begin
            r_n <= n_cnt;
        end
        if (emit) begin
            r_odigit <= e_digit;
            r_ofound <= e_found;
            r_olast  <= e_last;
        end
    end

    assign o_valid     = r_ovalid;
    assign o_digit_out = r_odigit;
    assign o_found     = r_ofound;
    assign o_last_out  = r_olast;

    // Checks
    `NPD_ASSERT_NOW(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(MAX_DIGITS))
    `NPD_ASSERT_NEXT(a_last_closes, i_clk, i_rst_n, accept && i_last_in,
        (r_state == npd_pkg::S_PREP) && (r_cnt == '0))
    `NPD_ASSERT_NOW(a_search_right, i_clk, i_rst_n, r_state == npd_pkg::S_SEARCH, r_addr > r_pos)
    `NPD_ASSERT_NOW(a_none_last, i_clk, i_rst_n, r_ovalid && !r_ofound, r_olast && (r_odigit == '0))

endmodule
`default_nettype wire
